@@ rtl/fbpa_pkg.sv @@
// ============================================================================
// fbpa_pkg - fixed block pool allocator shared definitions
// Types, constants and helpers used by the controller, datapath and top level.
// ============================================================================
`default_nettype none

package fbpa_pkg;

    // Pool geometry
    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = 7;
    localparam int CNT_W      = 7;
    localparam int POOL_W     = 7;
    localparam int POOL_RESET = 64;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] free_index;
    } t_in_word;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] granted_index;
        logic [CNT_W-1:0] in_use_count;
        logic             pool_full;
    } t_out_word;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic rebuild;
        logic capture;
        logic execute;
    } t_dp_cmd;

    // Limit a pool size write to 1..MAX_BLOCKS
    function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_W-1:0] v);
        logic [POOL_W-1:0] r;
        if (v == '0) begin
            r = POOL_W'(1);
        end else if (int'(v) > MAX_BLOCKS) begin
            r = POOL_W'(MAX_BLOCKS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fbpa_ctrl.sv @@
// ============================================================================
// fbpa_ctrl - allocator controller
// Sequences capture and execute of one command and owns the handshakes.
// ============================================================================
`default_nettype none

module fbpa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    output fbpa_pkg::t_dp_cmd     o_dp_cmd
);

    fbpa_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbpa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Output word slot is free next cycle if empty or being taken now
    always_comb begin
        o_cfg_ready = (r_state == fbpa_pkg::S_IDLE);
        o_in_stall  = !((r_state == fbpa_pkg::S_IDLE) && !i_cfg_valid &&
                        (!r_out_valid || !i_out_stall));
        in_accept   = i_in_valid && !o_in_stall;
        o_dp_cmd.rebuild = i_cfg_valid && o_cfg_ready;
        o_dp_cmd.capture = in_accept;
        o_dp_cmd.execute = (r_state == fbpa_pkg::S_EXEC);
        o_out_valid = r_out_valid;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = fbpa_pkg::S_EXEC;
                end
            end
            fbpa_pkg::S_EXEC: begin
                n_state = fbpa_pkg::S_IDLE;
            end
            default: begin
                n_state = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (r_state == fbpa_pkg::S_EXEC) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fbpa_dp.sv @@
// ============================================================================
// fbpa_dp - allocator datapath
// Link store, free head, allocated count, pool size and the result register.
// ============================================================================
`default_nettype none

module fbpa_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fbpa_pkg::t_dp_cmd               i_dp_cmd,
    input  wire fbpa_pkg::t_in_word              i_in_word,
    input  wire logic [fbpa_pkg::POOL_W-1:0]     i_cfg_data,
    output fbpa_pkg::t_out_word                  o_out_word
);

    logic [fbpa_pkg::LINK_W-1:0]     mem [fbpa_pkg::MAX_BLOCKS];
    logic [fbpa_pkg::MAX_BLOCKS-1:0] r_valid;
    logic [fbpa_pkg::LINK_W-1:0]     r_head, n_head;
    logic [fbpa_pkg::CNT_W-1:0]      r_count, n_count;
    logic [fbpa_pkg::POOL_W-1:0]     r_pool;
    fbpa_pkg::t_in_word              r_in;
    logic [fbpa_pkg::LINK_W-1:0]     r_rd_data;
    logic                            r_rd_valid;
    fbpa_pkg::t_out_word             r_out, n_out;
    logic [fbpa_pkg::IDX_W-1:0]      head_slot;
    logic [fbpa_pkg::LINK_W-1:0]     next_link;
    logic                            do_push;

    assign head_slot = r_head[fbpa_pkg::IDX_W-1:0];

    // Entry never written since rebuild links to its successor
    assign next_link = r_rd_valid ? r_rd_data
                     : fbpa_pkg::LINK_W'(head_slot) + fbpa_pkg::LINK_W'(1);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        do_push = 1'b0;
        n_out.status        = fbpa_pkg::ST_OK;
        n_out.granted_index = '0;
        if (r_in.cmd == fbpa_pkg::CMD_ALLOC) begin
            if (r_count >= r_pool) begin
                n_out.status = fbpa_pkg::ST_FULL;
            end else begin
                n_out.granted_index = head_slot;
                n_head  = next_link;
                n_count = r_count + fbpa_pkg::CNT_W'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_out.status = fbpa_pkg::ST_EMPTY;
            end else begin
                do_push = 1'b1;
                n_head  = fbpa_pkg::LINK_W'(r_in.free_index);
                n_count = r_count - fbpa_pkg::CNT_W'(1);
            end
        end
        n_out.in_use_count = n_count;
        n_out.pool_full    = (n_count == r_pool);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_pool  <= fbpa_pkg::clamp_pool(fbpa_pkg::POOL_W'(fbpa_pkg::POOL_RESET));
        end else if (i_dp_cmd.rebuild) begin
            r_valid <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_pool  <= fbpa_pkg::clamp_pool(i_cfg_data);
        end else if (i_dp_cmd.execute) begin
            r_head  <= n_head;
            r_count <= n_count;
            if (do_push) begin
                r_valid[r_in.free_index] <= 1'b1;
            end
        end
    end

    // Link store (head read on capture, push on execute), input and result regs
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_rd_data  <= mem[head_slot];
            r_rd_valid <= r_valid[head_slot];
            r_in       <= i_in_word;
        end
        if (i_dp_cmd.execute && do_push) begin
            mem[r_in.free_index] <= r_head;
        end
        if (i_dp_cmd.execute) begin
            r_out <= n_out;
        end
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire

@@ rtl/fixed_block_pool_allocator.sv @@
// ============================================================================
// fixed_block_pool_allocator - free-list pool allocator
// Hands out and takes back equal blocks of a pool, named by index.
// ============================================================================
// Each command (allocate or free) gives one result word. A command has two
// steps: the link store is read at the free head as the command is captured
// (a registered memory read), then head, count and link store are updated
// and the result register is loaded. No new command is taken in the second
// step or while a stalled result waits. Writing the pool size rebuilds the
// free list, as does reset; write it only while no command is in flight.
`default_nettype none

module fixed_block_pool_allocator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire fbpa_pkg::t_in_word          i_in_word,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output fbpa_pkg::t_out_word              o_out_word,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [fbpa_pkg::POOL_W-1:0] i_cfg_data
);

    fbpa_pkg::t_dp_cmd dp_cmd;

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_dp_cmd    (dp_cmd)
    );

    fbpa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dp_cmd   (dp_cmd),
        .i_in_word  (i_in_word),
        .i_cfg_data (i_cfg_data),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire
